// File: src/rv32i_execute_unit_top_assert.svh
// Assertion macros for the RV32I execute unit.
// Define NO_ASSERTIONS to compile them out.
`ifndef RV32I_EXECUTE_UNIT_TOP_ASSERT_SVH
`define RV32I_EXECUTE_UNIT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RVEX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rvex assertion failed");
`define RVEX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvex assertion failed");
`else
`define RVEX_ASSERT(lbl, prop)
`define RVEX_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// File: src/rvex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_pkg
// Types and encodings shared by the RV32I execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

  localparam logic [6:0] OPC_LUI    = 7'd55;
  localparam logic [6:0] OPC_AUIPC  = 7'd23;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_IMM    = 7'd19;
  localparam logic [6:0] OPC_REG    = 7'd51;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] WID_BYTE = 2'd0;
  localparam logic [1:0] WID_HALF = 2'd1;
  localparam logic [1:0] WID_WORD = 2'd2;

  localparam logic [31:0] LINK_STEP = 32'd4;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
    logic [31:0] pc;
  } in_item_t;

  typedef struct packed {
    logic        write_rd;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic [1:0]  mem_kind;
    logic [31:0] mem_addr;
    logic [1:0]  mem_width;
    logic        mem_unsigned;
    logic [31:0] store_data;
    logic        illegal;
  } out_item_t;

  // Decoded transaction handed from decode to execute
  typedef struct packed {
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic [2:0]  alu_f3;
    logic        alu_alt;
    logic [31:0] agu_a;
    logic [31:0] agu_b;
    logic [31:0] seq_pc;
    logic [31:0] cmp_a;
    logic [31:0] cmp_b;
    logic [2:0]  br_f3;
    logic        is_branch;
    logic        is_jump;
    logic        is_jalr;
    logic        wr_en;
    logic [4:0]  rd_index;
    logic [1:0]  mem_kind;
    logic [1:0]  mem_width;
    logic        mem_unsigned;
    logic [31:0] store_data;
    logic        illegal;
  } dec_t;

endpackage

// File: src/rvex_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_decode
// Input register and decode stage: immediates, operand select, legality.
// ----------------------------------------------------------------------------
module rvex_decode import rvex_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_load,
  input  in_item_t in_item,
  output logic     dec_valid,
  output dec_t     dec
);

  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s2_valid_r;
  dec_t     s2_dec_r;
  dec_t     dec_nxt;

  logic [31:0] ins;
  logic [31:0] ra;
  logic [31:0] rb;
  logic [31:0] pc;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic        ill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_load;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_item_r <= in_item;
    end
    if (s1_valid_r) begin
      s2_dec_r <= dec_nxt;
    end
  end

  assign ins = s1_item_r.instr;
  assign ra  = s1_item_r.src1_value;
  assign rb  = s1_item_r.src2_value;
  assign pc  = s1_item_r.pc;
  assign opc = ins[6:0];
  assign rd  = ins[11:7];
  assign f3  = ins[14:12];
  assign f7  = ins[31:25];

  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'd0};

  always_comb begin
    dec_nxt = '0;
    ill     = 1'b0;
    case (opc)
      OPC_LUI: begin
        dec_nxt.wr_en = 1'b1;
        dec_nxt.alu_b = imm_u;
      end
      OPC_AUIPC: begin
        dec_nxt.wr_en = 1'b1;
        dec_nxt.alu_a = pc;
        dec_nxt.alu_b = imm_u;
      end
      OPC_JAL: begin
        dec_nxt.wr_en   = 1'b1;
        dec_nxt.alu_a   = pc;
        dec_nxt.alu_b   = LINK_STEP;
        dec_nxt.agu_a   = pc;
        dec_nxt.agu_b   = imm_j;
        dec_nxt.is_jump = 1'b1;
      end
      OPC_JALR: begin
        ill             = (f3 != F3_ADD);
        dec_nxt.wr_en   = 1'b1;
        dec_nxt.alu_a   = pc;
        dec_nxt.alu_b   = LINK_STEP;
        dec_nxt.agu_a   = ra;
        dec_nxt.agu_b   = imm_i;
        dec_nxt.is_jump = 1'b1;
        dec_nxt.is_jalr = 1'b1;
      end
      OPC_BRANCH: begin
        ill = !((f3 == F3_BEQ) || (f3 == F3_BNE) || (f3 == F3_BLT) ||
                (f3 == F3_BGE) || (f3 == F3_BLTU) || (f3 == F3_BGEU));
        dec_nxt.agu_a     = pc;
        dec_nxt.agu_b     = imm_b;
        dec_nxt.cmp_a     = ra;
        dec_nxt.cmp_b     = rb;
        dec_nxt.br_f3     = f3;
        dec_nxt.is_branch = 1'b1;
      end
      OPC_LOAD: begin
        ill = !((f3 == F3_LB) || (f3 == F3_LH) || (f3 == F3_LW) ||
                (f3 == F3_LBU) || (f3 == F3_LHU));
        dec_nxt.wr_en        = 1'b1;
        dec_nxt.mem_kind     = MEM_LOAD;
        dec_nxt.agu_a        = ra;
        dec_nxt.agu_b        = imm_i;
        dec_nxt.mem_width    = f3[1:0];
        dec_nxt.mem_unsigned = f3[2];
      end
      OPC_STORE: begin
        dec_nxt.mem_kind  = MEM_STORE;
        dec_nxt.agu_a     = ra;
        dec_nxt.agu_b     = imm_s;
        dec_nxt.mem_width = f3[1:0];
        case (f3)
          F3_LB:   dec_nxt.store_data = {24'd0, rb[7:0]};
          F3_LH:   dec_nxt.store_data = {16'd0, rb[15:0]};
          F3_LW:   dec_nxt.store_data = rb;
          default: ill = 1'b1;
        endcase
      end
      OPC_IMM: begin
        ill = ((f3 == F3_SLL) && (f7 != F7_BASE)) ||
              ((f3 == F3_SR) && (f7 != F7_BASE) && (f7 != F7_ALT));
        dec_nxt.wr_en   = 1'b1;
        dec_nxt.alu_a   = ra;
        dec_nxt.alu_b   = imm_i;
        dec_nxt.alu_f3  = f3;
        dec_nxt.alu_alt = (f3 == F3_SR) && (f7 == F7_ALT);
      end
      OPC_REG: begin
        ill = (f7 != F7_BASE) &&
              !((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR)));
        dec_nxt.wr_en   = 1'b1;
        dec_nxt.alu_a   = ra;
        dec_nxt.alu_b   = rb;
        dec_nxt.alu_f3  = f3;
        dec_nxt.alu_alt = (f7 == F7_ALT);
      end
      default: ill = 1'b1;
    endcase

    if (ill) begin
      dec_nxt         = '0;
      dec_nxt.illegal = 1'b1;
    end
    if (dec_nxt.wr_en) begin
      dec_nxt.rd_index = rd;
    end
    dec_nxt.seq_pc = pc + LINK_STEP;
  end

  assign dec_valid = s2_valid_r;
  assign dec       = s2_dec_r;

endmodule

// File: src/rvex_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_alu
// Integer ALU shared by OP, OP-IMM, upper-immediate and link operations.
// ----------------------------------------------------------------------------
module rvex_alu import rvex_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [2:0]  f3,
  input  logic        alt,
  output logic [31:0] y
);

  logic [4:0] shamt;

  assign shamt = b[4:0];

  always_comb begin
    case (f3)
      F3_ADD:  y = alt ? (a - b) : (a + b);
      F3_SLL:  y = a << shamt;
      F3_SLT:  y = {31'd0, ($signed(a) < $signed(b))};
      F3_SLTU: y = {31'd0, (a < b)};
      F3_XOR:  y = a ^ b;
      F3_SR:   y = alt ? 32'($signed(a) >>> shamt) : (a >> shamt);
      F3_OR:   y = a | b;
      F3_AND:  y = a & b;
      default: y = '0;
    endcase
  end

endmodule

// File: src/rvex_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_execute
// Execute stage: ALU, address/target adder, branch resolve, result register.
// ----------------------------------------------------------------------------
module rvex_execute import rvex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      dec_valid,
  input  dec_t      dec,
  output logic      out_valid,
  output out_item_t out_item
);

  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;
  logic [31:0] alu_y;
  logic [31:0] agu_sum;
  logic        eq;
  logic        lt;
  logic        ltu;
  logic        taken;

  rvex_alu u_alu (
    .a   (dec.alu_a),
    .b   (dec.alu_b),
    .f3  (dec.alu_f3),
    .alt (dec.alu_alt),
    .y   (alu_y)
  );

  assign agu_sum = dec.agu_a + dec.agu_b;
  assign eq      = (dec.cmp_a == dec.cmp_b);
  assign lt      = ($signed(dec.cmp_a) < $signed(dec.cmp_b));
  assign ltu     = (dec.cmp_a < dec.cmp_b);

  always_comb begin
    case (dec.br_f3)
      F3_BEQ:  taken = eq;
      F3_BNE:  taken = !eq;
      F3_BLT:  taken = lt;
      F3_BGE:  taken = !lt;
      F3_BLTU: taken = ltu;
      F3_BGEU: taken = !ltu;
      default: taken = 1'b0;
    endcase
  end

  always_comb begin
    out_item_nxt              = '0;
    out_item_nxt.write_rd     = dec.wr_en && (dec.rd_index != '0);
    out_item_nxt.rd_index     = dec.rd_index;
    out_item_nxt.rd_value     = alu_y;
    out_item_nxt.mem_kind     = dec.mem_kind;
    out_item_nxt.mem_width    = dec.mem_width;
    out_item_nxt.mem_unsigned = dec.mem_unsigned;
    out_item_nxt.store_data   = dec.store_data;
    out_item_nxt.illegal      = dec.illegal;
    if (dec.mem_kind != MEM_NONE) begin
      out_item_nxt.mem_addr = agu_sum;
    end
    if (dec.is_jalr) begin
      out_item_nxt.next_pc = {agu_sum[31:1], 1'b0};
    end else if (dec.is_jump || (dec.is_branch && taken)) begin
      out_item_nxt.next_pc = agu_sum;
    end else begin
      out_item_nxt.next_pc = dec.seq_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: src/rv32i_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top
// RV32I integer execute unit: decode, execute, branch resolve, memory request.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item (instr, src1_value, src2_value, pc) and raise start.
//   A transaction is taken on every rising edge with start high and busy low;
//   busy stays low, so one instruction can enter every cycle.
//   Output: out_valid is high for one cycle with the result in out_item
//   (register write, next pc, memory request, illegal flag).
//   Stages, in order: input register, decode register, execute/result
//   register. Throughput is one instruction per cycle, set by the three-stage
//   pipeline with no shared unit or loop.
//   The receiver cannot stall; each result is shown exactly once.
//   Synchronous active-low reset clears all stage valid bits; transactions in
//   flight are dropped and no result appears until new input enters.
// ----------------------------------------------------------------------------
`include "rv32i_execute_unit_top_assert.svh"

module rv32i_execute_unit_top import rvex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic in_load;
  logic dec_valid;
  dec_t dec;

  assign busy    = 1'b0;
  assign in_load = start && !busy;

  rvex_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_load   (in_load),
    .in_item   (in_item),
    .dec_valid (dec_valid),
    .dec       (dec)
  );

  rvex_execute u_execute (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec       (dec),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `RVEX_ASSERT_IMPL(a_latency, out_valid, $past(start, 3))
  `RVEX_ASSERT_IMPL(a_illegal_quiet, out_valid && out_item.illegal,
    !out_item.write_rd && (out_item.mem_kind == MEM_NONE) && (out_item.rd_index == '0))
  `RVEX_ASSERT_IMPL(a_x0_no_write, out_valid && (out_item.rd_index == '0), !out_item.write_rd)
  `RVEX_ASSERT(a_mem_kind, !out_valid || (out_item.mem_kind == MEM_NONE) ||
    (out_item.mem_kind == MEM_LOAD) || (out_item.mem_kind == MEM_STORE))

endmodule
